FILE: rtl/plc_pkg.sv
package plc_pkg;

  localparam logic [4:0] CMD_SCAN = 5'd0;
  localparam logic [4:0] CMD_LD   = 5'd1;
  localparam logic [4:0] CMD_LDI  = 5'd2;
  localparam logic [4:0] CMD_LDKH = 5'd3;
  localparam logic [4:0] CMD_LDKL = 5'd4;
  localparam logic [4:0] CMD_AND  = 5'd5;
  localparam logic [4:0] CMD_ANI  = 5'd6;
  localparam logic [4:0] CMD_OR   = 5'd7;
  localparam logic [4:0] CMD_ORI  = 5'd8;
  localparam logic [4:0] CMD_LDP  = 5'd9;
  localparam logic [4:0] CMD_LDF  = 5'd10;
  localparam logic [4:0] CMD_ANDP = 5'd11;
  localparam logic [4:0] CMD_ANDF = 5'd12;
  localparam logic [4:0] CMD_ORP  = 5'd13;
  localparam logic [4:0] CMD_ORF  = 5'd14;
  localparam logic [4:0] CMD_MPS  = 5'd15;
  localparam logic [4:0] CMD_MRD  = 5'd16;
  localparam logic [4:0] CMD_MPP  = 5'd17;
  localparam logic [4:0] CMD_OUT  = 5'd18;
  localparam logic [4:0] CMD_SET  = 5'd19;
  localparam logic [4:0] CMD_RST  = 5'd20;
  localparam logic [4:0] CMD_TGL  = 5'd21;
  localparam logic [4:0] CMD_INV  = 5'd22;
  localparam logic [4:0] CMD_OUTT = 5'd23;
  localparam logic [4:0] CMD_OUTC = 5'd24;
  localparam logic [4:0] CMD_END  = 5'd25;
  localparam logic [4:0] CMD_NOP  = 5'd26;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef enum logic [2:0] {
    REG_IN, REG_OUT, REG_AUX, REG_TF, REG_TS, REG_CNT, REG_BAD
  } region_e;

  // classified item passed from front to back
  typedef struct packed {
    logic [4:0]  cmd;
    region_e     region;
    logic [15:0] idx;
    logic [15:0] k_value;
    logic [15:0] input_pins;
    logic [15:0] ticks_100ms;
    logic [15:0] ticks_1s;
  } item_t;

endpackage

FILE: rtl/plc_bit_logic_instruction_executor.sv
// PLC bit instruction executor.
// Input channel: in_valid_i / in_stall_o carry one instruction item (cmd,
// operand address, preset, pin sample, tick counts). Output channel:
// out_valid_o / out_stall_i carry one result item per instruction.
// A front stage classifies the operand address into a region and index and
// pushes into a two-entry queue; the back stage executes one item per cycle
// out of that queue while the receiver does not stall and no END sweep runs.
// An accepted item is written into the queue, then executed from there into
// the result register. END additionally runs a timer aging sweep, one timer
// entry of each bank per cycle, and its result is valid once the sweep ends;
// items behind it wait in the queue.
// Reset clears every image, timer, counter, the stack and the stopped flag.
// While the receiver stalls, the held result stays put, the back stage stops,
// and the queue fills; the input stalls once the queue is full.
// After an error the block answers every item with status 2 until reset.
module plc_bit_logic_instruction_executor import plc_pkg::*; #(
  parameter int INPUT_COUNT   = 16,
  parameter int OUTPUT_COUNT  = 16,
  parameter int AUX_COUNT     = 64,
  parameter int TIMER_COUNT   = 16,
  parameter int COUNTER_COUNT = 16,
  parameter int STACK_DEPTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  cmd_i,
  input  logic [15:0] operand_addr_i,
  input  logic [15:0] k_value_i,
  input  logic [15:0] input_pins_i,
  input  logic [15:0] ticks_100ms_i,
  input  logic [15:0] ticks_1s_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accumulator_o,
  output logic [15:0] output_bits_o,
  output logic        scan_done_o,
  output logic [1:0]  status_o
);
  logic  q_valid, q_pop;
  item_t q_item;

  plc_front #(
    .INPUT_COUNT(INPUT_COUNT), .OUTPUT_COUNT(OUTPUT_COUNT), .AUX_COUNT(AUX_COUNT),
    .TIMER_COUNT(TIMER_COUNT), .COUNTER_COUNT(COUNTER_COUNT)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .operand_addr_i,
    .k_value_i, .input_pins_i, .ticks_100ms_i, .ticks_1s_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  plc_back #(
    .INPUT_COUNT(INPUT_COUNT), .OUTPUT_COUNT(OUTPUT_COUNT), .AUX_COUNT(AUX_COUNT),
    .TIMER_COUNT(TIMER_COUNT), .COUNTER_COUNT(COUNTER_COUNT),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .accumulator_o, .output_bits_o, .scan_done_o,
    .status_o
  );
endmodule

FILE: rtl/plc_front.sv
module plc_front import plc_pkg::*; #(
  parameter int INPUT_COUNT   = 16,
  parameter int OUTPUT_COUNT  = 16,
  parameter int AUX_COUNT     = 64,
  parameter int TIMER_COUNT   = 16,
  parameter int COUNTER_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  cmd_i,
  input  logic [15:0] operand_addr_i,
  input  logic [15:0] k_value_i,
  input  logic [15:0] input_pins_i,
  input  logic [15:0] ticks_100ms_i,
  input  logic [15:0] ticks_1s_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output item_t       q_item_o
);
  localparam int BaseOut = INPUT_COUNT;
  localparam int BaseAux = BaseOut + OUTPUT_COUNT;
  localparam int BaseTf  = BaseAux + AUX_COUNT;
  localparam int BaseTs  = BaseTf + TIMER_COUNT;
  localparam int BaseCnt = BaseTs + TIMER_COUNT;
  localparam int BaseEnd = BaseCnt + COUNTER_COUNT;

  item_t       cls;
  logic [16:0] a;

  // address classification
  always_comb begin
    a = {1'b0, operand_addr_i};
    cls.cmd = cmd_i;
    cls.k_value = k_value_i;
    cls.input_pins = input_pins_i;
    cls.ticks_100ms = ticks_100ms_i;
    cls.ticks_1s = ticks_1s_i;
    cls.region = REG_BAD;
    cls.idx = '0;
    if (a < 17'(BaseOut)) begin
      cls.region = REG_IN;  cls.idx = a[15:0];
    end else if (a < 17'(BaseAux)) begin
      cls.region = REG_OUT; cls.idx = 16'(a - 17'(BaseOut));
    end else if (a < 17'(BaseTf)) begin
      cls.region = REG_AUX; cls.idx = 16'(a - 17'(BaseAux));
    end else if (a < 17'(BaseTs)) begin
      cls.region = REG_TF;  cls.idx = 16'(a - 17'(BaseTf));
    end else if (a < 17'(BaseCnt)) begin
      cls.region = REG_TS;  cls.idx = 16'(a - 17'(BaseTs));
    end else if (a < 17'(BaseEnd)) begin
      cls.region = REG_CNT; cls.idx = 16'(a - 17'(BaseCnt));
    end
  end

  // two-entry queue
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = cnt_q[1];
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (q_pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

FILE: rtl/plc_back.sv
module plc_back import plc_pkg::*; #(
  parameter int INPUT_COUNT   = 16,
  parameter int OUTPUT_COUNT  = 16,
  parameter int AUX_COUNT     = 64,
  parameter int TIMER_COUNT   = 16,
  parameter int COUNTER_COUNT = 16,
  parameter int STACK_DEPTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accumulator_o,
  output logic [15:0] output_bits_o,
  output logic        scan_done_o,
  output logic [1:0]  status_o
);
  localparam int TW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int IXW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int OXW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
  localparam int AXW = (AUX_COUNT > 1) ? $clog2(AUX_COUNT) : 1;
  localparam int CXW = (COUNTER_COUNT > 1) ? $clog2(COUNTER_COUNT) : 1;

  localparam logic [1:0] S_EXEC = 2'd0;
  localparam logic [1:0] S_AGE  = 2'd1;

  logic [1:0] state_q, state_d;

  logic acc_q, stopped_q;
  logic [STACK_DEPTH-1:0] stk_q;
  logic [SW-1:0] sp_q;
  logic [INPUT_COUNT-1:0] in_now_q, in_prev_q;
  logic [OUTPUT_COUNT-1:0] out_now_q, out_prev_q;
  logic [AUX_COUNT-1:0] aux_q, aux_prev_q;
  logic [TIMER_COUNT-1:0] ften_q, ftev_q, ftevp_q, sten_q, stev_q, stevp_q;
  logic [15:0] ftc_q [TIMER_COUNT];
  logic [15:0] stc_q [TIMER_COUNT];
  logic [COUNTER_COUNT-1:0] cev_q, cevp_q, ctrig_q;
  logic [15:0] cval_q [COUNTER_COUNT];
  logic [TW-1:0] ai_q;
  logic [15:0] t100_q, t1s_q;

  logic res_full_q;
  logic res_acc_q, res_done_q;
  logic [15:0] res_bits_q;
  logic [1:0] res_st_q;

  item_t it;
  assign it = q_item_i;

  // per-region element index
  logic [IXW-1:0] ix_in;
  logic [OXW-1:0] ix_out;
  logic [AXW-1:0] ix_aux;
  logic [TW-1:0]  ix_tmr;
  logic [CXW-1:0] ix_cnt;
  assign ix_in  = it.idx[IXW-1:0];
  assign ix_out = it.idx[OXW-1:0];
  assign ix_aux = it.idx[AXW-1:0];
  assign ix_tmr = it.idx[TW-1:0];
  assign ix_cnt = it.idx[CXW-1:0];

  logic can_out;
  assign can_out = !res_full_q || !out_stall_i;

  // operand read of the current and last-scan images
  logic cur, last, inv, edge_b;
  always_comb begin
    cur = 1'b0; last = 1'b0;
    case (it.region)
      REG_IN:  begin cur = in_now_q[ix_in];   last = in_prev_q[ix_in];   end
      REG_OUT: begin cur = out_now_q[ix_out]; last = out_prev_q[ix_out]; end
      REG_AUX: begin cur = aux_q[ix_aux];     last = aux_prev_q[ix_aux]; end
      REG_TF:  begin cur = ftev_q[ix_tmr];    last = ftevp_q[ix_tmr];    end
      REG_TS:  begin cur = stev_q[ix_tmr];    last = stevp_q[ix_tmr];    end
      REG_CNT: begin cur = cev_q[ix_cnt];     last = cevp_q[ix_cnt];     end
      default: ;
    endcase
    inv = (it.cmd == CMD_ANI) || (it.cmd == CMD_ORI) || (it.cmd == CMD_LDI);
    edge_b = ((it.cmd == CMD_LDP) || (it.cmd == CMD_ANDP) || (it.cmd == CMD_ORP))
           ? (cur && !last) : (!cur && last);
  end

  // execution of one instruction: new accumulator, error and write intent
  logic acc_n, err, wr, wv, bad;
  always_comb begin
    bad = it.region == REG_BAD;
    acc_n = acc_q; err = 1'b0; wr = 1'b0; wv = 1'b0;
    case (it.cmd)
      CMD_SCAN, CMD_NOP, CMD_END: ;
      CMD_LD, CMD_LDI: begin err = bad; acc_n = cur ^ inv; end
      CMD_LDKH: acc_n = 1'b1;
      CMD_LDKL: acc_n = 1'b0;
      CMD_AND, CMD_ANI: begin err = bad; acc_n = acc_q & (cur ^ inv); end
      CMD_OR, CMD_ORI: begin err = bad; acc_n = acc_q | (cur ^ inv); end
      CMD_LDP, CMD_LDF: begin err = bad; acc_n = edge_b; end
      CMD_ANDP, CMD_ANDF: begin err = bad; acc_n = acc_q & edge_b; end
      CMD_ORP, CMD_ORF: begin err = bad; acc_n = acc_q | edge_b; end
      CMD_MPS: err = sp_q >= SW'(STACK_DEPTH);
      CMD_MRD: begin
        err = sp_q == '0;
        acc_n = stk_q[SIW'(sp_q - SW'(1))];
      end
      CMD_MPP: begin
        err = sp_q == '0;
        acc_n = stk_q[SIW'(sp_q - SW'(1))];
      end
      CMD_OUT: begin wr = 1'b1; wv = acc_q; end
      CMD_SET: begin wr = acc_q; wv = 1'b1; end
      CMD_RST: begin wr = acc_q; wv = 1'b0; end
      CMD_TGL: begin wr = acc_q; wv = !cur; end
      CMD_INV: acc_n = !acc_q;
      CMD_OUTT: err = !(it.region == REG_TF || it.region == REG_TS);
      CMD_OUTC: err = it.region != REG_CNT;
      default: err = 1'b1;
    endcase
    if (wr && (bad || it.region == REG_TF || it.region == REG_TS)) err = 1'b1;
  end

  logic exec_go;
  logic end_pop;
  assign exec_go = (state_q == S_EXEC) && q_valid_i && can_out;
  // END pops its queue entry when the sweep finishes
  assign end_pop = (state_q == S_AGE) && (ai_q == TW'(TIMER_COUNT - 1));
  assign q_pop_o = (exec_go && !(it.cmd == CMD_END && !stopped_q)) || end_pop;

  // sequencer: END ages timers one entry per cycle before popping
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_EXEC: if (exec_go && !stopped_q && it.cmd == CMD_END) state_d = S_AGE;
      S_AGE: if (ai_q == TW'(TIMER_COUNT - 1)) state_d = S_EXEC;
      default: state_d = S_EXEC;
    endcase
  end

  logic [15:0] fc, sc;
  assign fc = ftc_q[ai_q];
  assign sc = stc_q[ai_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EXEC; acc_q <= 1'b0; stopped_q <= 1'b0;
      stk_q <= '0; sp_q <= '0;
      in_now_q <= '0; in_prev_q <= '0; out_now_q <= '0; out_prev_q <= '0;
      aux_q <= '0; aux_prev_q <= '0;
      ften_q <= '0; ftev_q <= '0; ftevp_q <= '0;
      sten_q <= '0; stev_q <= '0; stevp_q <= '0;
      cev_q <= '0; cevp_q <= '0; ctrig_q <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        ftc_q[i] <= '0; stc_q[i] <= '0;
      end
      for (int i = 0; i < COUNTER_COUNT; i++) cval_q[i] <= '0;
      ai_q <= '0; t100_q <= '0; t1s_q <= '0;
      res_full_q <= 1'b0;
      res_acc_q <= 1'b0; res_done_q <= 1'b0; res_bits_q <= '0; res_st_q <= ST_OK;
    end else begin
      state_q <= state_d;
      if (res_full_q && !out_stall_i) res_full_q <= 1'b0;
      if (exec_go) begin
        res_full_q <= 1'b1;
        res_bits_q <= '0;
        res_done_q <= 1'b0;
        if (stopped_q) begin
          res_acc_q <= acc_q; res_st_q <= ST_IGNORED;
        end else if (err) begin
          stopped_q <= 1'b1; res_acc_q <= acc_q; res_st_q <= ST_ERROR;
        end else begin
          acc_q <= acc_n; res_acc_q <= acc_n; res_st_q <= ST_OK;
          case (it.cmd)
            CMD_SCAN: for (int i = 0; i < INPUT_COUNT; i++)
              in_now_q[i] <= (i < 16) ? it.input_pins[i % 16] : 1'b0;
            CMD_MPS: begin
              stk_q[SIW'(sp_q)] <= acc_q; sp_q <= sp_q + SW'(1);
            end
            CMD_MPP: sp_q <= sp_q - SW'(1);
            CMD_OUTT: begin
              if (it.region == REG_TF) begin
                if (acc_q) begin
                  if (!ften_q[ix_tmr]) begin
                    ftc_q[ix_tmr] <= it.k_value; ften_q[ix_tmr] <= 1'b1;
                    ftev_q[ix_tmr] <= 1'b0;
                  end
                end else ften_q[ix_tmr] <= 1'b0;
              end else begin
                if (acc_q) begin
                  if (!sten_q[ix_tmr]) begin
                    stc_q[ix_tmr] <= it.k_value; sten_q[ix_tmr] <= 1'b1;
                    stev_q[ix_tmr] <= 1'b0;
                  end
                end else sten_q[ix_tmr] <= 1'b0;
              end
            end
            CMD_OUTC: begin
              if (acc_q && !ctrig_q[ix_cnt] && cval_q[ix_cnt] < it.k_value) begin
                cval_q[ix_cnt] <= cval_q[ix_cnt] + 16'd1;
                if (cval_q[ix_cnt] + 16'd1 == it.k_value) cev_q[ix_cnt] <= 1'b1;
              end
              ctrig_q[ix_cnt] <= acc_q;
            end
            CMD_END: begin
              out_prev_q <= out_now_q; in_prev_q <= in_now_q;
              aux_prev_q <= aux_q; ftevp_q <= ftev_q; stevp_q <= stev_q;
              cevp_q <= cev_q;
              for (int i = 0; i < 16; i++)
                res_bits_q[i] <= (i < OUTPUT_COUNT) ? out_now_q[i % OUTPUT_COUNT] : 1'b0;
              res_done_q <= 1'b1;
              res_full_q <= 1'b0;
              ai_q <= '0; t100_q <= it.ticks_100ms; t1s_q <= it.ticks_1s;
            end
            default: ;
          endcase
          if (wr) begin
            case (it.region)
              REG_OUT: out_now_q[ix_out] <= wv;
              REG_AUX: aux_q[ix_aux] <= wv;
              REG_CNT: if (!wv) begin
                cval_q[ix_cnt] <= '0; cev_q[ix_cnt] <= 1'b0;
              end
              default: ;
            endcase
          end
        end
      end
      // timer aging sweep
      if (state_q == S_AGE) begin
        if (ften_q[ai_q]) begin
          if (t100_q != 16'd0 && !ftev_q[ai_q]) begin
            ftc_q[ai_q] <= (fc > t100_q) ? fc - t100_q : 16'd0;
            if (fc <= t100_q) ftev_q[ai_q] <= 1'b1;
          end
        end else begin
          ftc_q[ai_q] <= '0; ftev_q[ai_q] <= 1'b0;
        end
        if (sten_q[ai_q]) begin
          if (t1s_q != 16'd0 && !stev_q[ai_q]) begin
            stc_q[ai_q] <= (sc > t1s_q) ? sc - t1s_q : 16'd0;
            if (sc <= t1s_q) stev_q[ai_q] <= 1'b1;
          end
        end else begin
          stc_q[ai_q] <= '0; stev_q[ai_q] <= 1'b0;
        end
        ai_q <= ai_q + TW'(1);
        if (ai_q == TW'(TIMER_COUNT - 1)) res_full_q <= 1'b1;
      end
    end
  end

  assign out_valid_o   = res_full_q;
  assign accumulator_o = res_acc_q;
  assign output_bits_o = res_bits_q;
  assign scan_done_o   = res_done_q;
  assign status_o      = res_st_q;
endmodule
